/* design/zlp_pkg.sv */
package zlp_pkg;

   localparam int DEF_MAX_FEATURES = 256;
   localparam int DEF_MAX_OUTPUTS  = 8;
   localparam int DEF_FRAC_BITS    = 16;

   // At most this many result items follow one vector.
   localparam int RESULT_LIMIT = 8;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;

   localparam logic [1:0] CMD_FEAT_STATS = 2'd0;
   localparam logic [1:0] CMD_COEF       = 2'd1;
   localparam logic [1:0] CMD_OUT_STATS  = 2'd2;
   localparam logic [1:0] CMD_SAMPLE     = 2'd3;

   localparam logic [1:0] REG_MODE         = 2'd0;
   localparam logic [1:0] REG_FEATURES_USE = 2'd1;
   localparam logic [1:0] REG_OUTPUTS_USE  = 2'd2;

   localparam logic MODE_REGRESSION = 1'b0;

   typedef struct packed {
      logic signed [ACC_W-1:0]  acc;
      logic signed [DATA_W-1:0] omean;
      logic signed [DATA_W-1:0] odev;
   } cell_data_type;

endpackage

/* design/zlp_cell.sv */
module zlp_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift_en,
   input  zlp_pkg::cell_data_type    data_in,
   input  logic                      stat_we,
   input  logic signed [31:0]        stat_mean,
   input  logic signed [31:0]        stat_dev,
   output zlp_pkg::cell_data_type    data_out
);

   logic signed [zlp_pkg::ACC_W-1:0]  acc_ff;
   logic signed [zlp_pkg::DATA_W-1:0] omean_ff;
   logic signed [zlp_pkg::DATA_W-1:0] odev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (shift_en) begin
         acc_ff <= data_in.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         omean_ff <= data_in.omean;
         odev_ff  <= data_in.odev;
      end else if (stat_we) begin
         omean_ff <= stat_mean;
         odev_ff  <= stat_dev;
      end
   end

   assign data_out.acc   = acc_ff;
   assign data_out.omean = omean_ff;
   assign data_out.odev  = odev_ff;

endmodule

/* design/zlp_divider.sv */
module zlp_divider #(
   parameter int FRAC_BITS = zlp_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [32+FRAC_BITS:0]     numer,
   input  logic signed [31:0]               denom,
   output logic                             done,
   output logic signed [31:0]               quot,
   output logic                             sat
);

   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] q_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      den_ff;
   logic             neg_ff;
   logic [32:0]      trial;
   logic             take;

   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(NUM_W)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Restoring division on magnitudes, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
         den_ff <= denom[31] ? 32'(-denom) : 32'(denom);
         rem_ff <= '0;
         neg_ff <= numer[NUM_W-1] ^ denom[31];
      end else if (busy_ff && cnt_ff != CNT_W'(NUM_W)) begin
         rem_ff <= take ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         q_ff   <= {q_ff[NUM_W-2:0], take};
      end
   end

   assign done = busy_ff && cnt_ff == CNT_W'(NUM_W);

   always_comb begin
      sat  = 1'b0;
      quot = '0;
      if (neg_ff) begin
         if (q_ff > NUM_W'(33'h080000000)) begin
            sat  = 1'b1;
            quot = 32'sh80000000;
         end else begin
            quot = 32'(-q_ff);
         end
      end else begin
         if (q_ff > NUM_W'(33'h07FFFFFFF)) begin
            sat  = 1'b1;
            quot = 32'sh7FFFFFFF;
         end else begin
            quot = 32'(q_ff);
         end
      end
   end

endmodule

/* design/zscore_linear_projection.sv */
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   command, indexes, value_a, value_b, last mark
// rsp      out        rsp_valid/rsp_ready   result_index, prediction, fault, last_result
// csr      in         csr_we                csr_index, csr_wdata
// A load item is written while the block stays idle. A sample item passes through the
// bit-serial divider and then, for each output, the shared multiply-accumulate;
// a zero deviation or an unused feature skips the divider. No new item is taken until
// the last one is done. The item that ends a vector adds output scaling for each
// output, then the accumulator ring turns home, stalled by rsp_ready.
// Reset is synchronous; it clears the accumulators and the fault flag, not the tables.
module zscore_linear_projection #(
   parameter int MAX_FEATURES = zlp_pkg::DEF_MAX_FEATURES,
   parameter int MAX_OUTPUTS  = zlp_pkg::DEF_MAX_OUTPUTS,
   parameter int FRAC_BITS    = zlp_pkg::DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_feature_index,
   input  logic [2:0]         req_output_index,
   input  logic signed [31:0] req_value_a,
   input  logic signed [31:0] req_value_b,
   input  logic               req_last_feature,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_result_index,
   output logic signed [31:0] rsp_prediction,
   output logic               rsp_fault,
   output logic               rsp_last_result,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_wdata
);

   localparam int FA_W   = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
   localparam int CDEPTH = MAX_FEATURES * MAX_OUTPUTS;
   localparam int CA_W   = CDEPTH > 1 ? $clog2(CDEPTH) : 1;
   localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);
   localparam int FU_W   = $clog2(MAX_FEATURES + 1);
   localparam int EMIT_MAX = MAX_OUTPUTS < zlp_pkg::RESULT_LIMIT ?
                             MAX_OUTPUTS : zlp_pkg::RESULT_LIMIT;
   localparam int FU_RESET = MAX_FEATURES < 256 ? MAX_FEATURES : 256;
   localparam int NUM_W  = 33 + FRAC_BITS;
   localparam int ACC_W  = zlp_pkg::ACC_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_MRD   = 4'd3;
   localparam logic [3:0] S_MMUL  = 4'd4;
   localparam logic [3:0] S_MADD  = 4'd5;
   localparam logic [3:0] S_EMUL  = 4'd6;
   localparam logic [3:0] S_EADD  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic               mode_ff;
   logic [FU_W-1:0]    feat_use_ff;
   logic [3:0]         out_use_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               fault_ff, fault_in;
   logic               last_ff, last_in;
   logic [FA_W-1:0]    fa_ff;
   logic signed [31:0] x_ff;
   logic signed [31:0] z_ff, z_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] s_ff, s_in;

   logic [63:0]        fmem [MAX_FEATURES];
   logic [63:0]        fq_ff;
   logic [31:0]        cmem [CDEPTH];
   logic signed [31:0] cq_ff;

   logic               req_fire;
   logic               fi_ok, oi_ok, fi_used;
   logic [FA_W-1:0]    req_fa;
   logic [CA_W-1:0]    coef_addr;

   logic               div_start, div_done, div_sat;
   logic signed [NUM_W-1:0] div_num;
   logic signed [31:0] div_quot;
   logic signed [32:0] diff;
   logic signed [31:0] fmean, fdev;

   logic               shift_en;
   zlp_pkg::cell_data_type tail_in;
   zlp_pkg::cell_data_type head;
   zlp_pkg::cell_data_type cell_out [MAX_OUTPUTS];
   logic signed [ACC_W-1:0] acc_new;

   logic               in_range;

   assign req_fire = req_valid && req_ready;
   assign req_ready = state_ff == S_IDLE;
   assign fi_ok = 32'(req_feature_index) < MAX_FEATURES;
   assign oi_ok = 32'(req_output_index) < MAX_OUTPUTS;
   assign fi_used = fi_ok && 32'(req_feature_index) < 32'(feat_use_ff);
   assign req_fa = FA_W'(req_feature_index);

   // Configuration registers, clamped on write.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= zlp_pkg::MODE_REGRESSION;
         feat_use_ff <= FU_W'(FU_RESET);
         out_use_ff  <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            zlp_pkg::REG_MODE: mode_ff <= csr_wdata[0];
            zlp_pkg::REG_FEATURES_USE: begin
               if (csr_wdata == 9'd0) begin
                  feat_use_ff <= FU_W'(1);
               end else if (32'(csr_wdata) > MAX_FEATURES) begin
                  feat_use_ff <= FU_W'(MAX_FEATURES);
               end else begin
                  feat_use_ff <= FU_W'(csr_wdata);
               end
            end
            zlp_pkg::REG_OUTPUTS_USE: begin
               if (csr_wdata[3:0] == 4'd0) begin
                  out_use_ff <= 4'd1;
               end else if (32'(csr_wdata[3:0]) > EMIT_MAX) begin
                  out_use_ff <= 4'(EMIT_MAX);
               end else begin
                  out_use_ff <= csr_wdata[3:0];
               end
            end
            default: ;
         endcase
      end
   end

   // Feature statistics: mean in the upper half, deviation in the lower half.
   always_ff @(posedge clock) begin
      if (req_fire && req_command == zlp_pkg::CMD_FEAT_STATS && fi_ok) begin
         fmem[req_fa] <= {req_value_a, req_value_b};
      end
      if (req_fire && req_command == zlp_pkg::CMD_SAMPLE) begin
         fq_ff <= fmem[req_fa];
      end
   end

   assign coef_addr = CA_W'(fa_ff) * CA_W'(MAX_OUTPUTS) + CA_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (req_fire && req_command == zlp_pkg::CMD_COEF && fi_ok && oi_ok) begin
         cmem[CA_W'(req_fa) * CA_W'(MAX_OUTPUTS) + CA_W'(req_output_index)] <= req_value_a;
      end
      if (state_ff == S_MRD) begin
         cq_ff <= cmem[coef_addr];
      end
   end

   assign fmean = fq_ff[63:32];
   assign fdev  = fq_ff[31:0];
   assign diff  = 33'(x_ff) - 33'(fmean);
   assign div_num = NUM_W'(diff) <<< FRAC_BITS;
   assign div_start = state_ff == S_FETCH && fdev != 32'sd0;

   zlp_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (fdev),
      .done  (div_done),
      .quot  (div_quot),
      .sat   (div_sat)
   );

   // Ring of accumulator cells; cell 0 is the head that the shared unit works on.
   genvar gi;
   generate
      for (gi = 0; gi < MAX_OUTPUTS; gi++) begin : g_cell
         zlp_pkg::cell_data_type cin;
         if (gi == MAX_OUTPUTS - 1) begin : g_tail
            assign cin = tail_in;
         end else begin : g_mid
            assign cin = cell_out[gi+1];
         end
         zlp_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .data_in   (cin),
            .stat_we   (req_fire && req_command == zlp_pkg::CMD_OUT_STATS && oi_ok &&
                        32'(req_output_index) == gi),
            .stat_mean (req_value_a),
            .stat_dev  (req_value_b),
            .data_out  (cell_out[gi])
         );
      end
   endgenerate

   assign head = cell_out[0];
   assign in_range = 32'(cnt_ff) < 32'(out_use_ff);

   always_comb begin
      logic signed [ACC_W:0] sum65;
      logic signed [63:0]    scaled;
      logic signed [63:0]    biased;
      logic signed [31:0]    val;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      fault_in = fault_ff;
      last_in  = last_ff;
      z_in     = z_ff;
      prod_in  = prod_ff;
      s_in     = s_ff;
      shift_en = 1'b0;
      tail_in  = head;
      acc_new  = head.acc;
      sum65    = '0;
      scaled   = '0;
      biased   = '0;
      val      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_command == zlp_pkg::CMD_SAMPLE) begin
               last_in = req_last_feature;
               cnt_in  = '0;
               if (fi_used) begin
                  state_in = S_FETCH;
               end else if (req_last_feature) begin
                  state_in = S_EMUL;
               end
            end
         end
         S_FETCH: begin
            if (fdev == 32'sd0) begin
               fault_in = 1'b1;
               if (diff > 33'sd0) begin
                  z_in = 32'sh7FFFFFFF;
               end else if (diff < 33'sd0) begin
                  z_in = 32'sh80000000;
               end else begin
                  z_in = 32'sd0;
               end
               state_in = S_MRD;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               z_in = div_quot;
               if (div_sat) begin
                  fault_in = 1'b1;
               end
               state_in = S_MRD;
            end
         end
         S_MRD: state_in = S_MMUL;
         S_MMUL: begin
            prod_in  = z_ff * cq_ff;
            state_in = S_MADD;
         end
         S_MADD: begin
            sum65 = {head.acc[ACC_W-1], head.acc} + 65'(prod_ff >>> FRAC_BITS);
            if (sum65[ACC_W] != sum65[ACC_W-1]) begin
               fault_in = 1'b1;
               acc_new = sum65[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
               acc_new = sum65[ACC_W-1:0];
            end
            tail_in.acc = acc_new;
            shift_en = 1'b1;
            if (32'(cnt_ff) == MAX_OUTPUTS - 1) begin
               cnt_in   = '0;
               state_in = last_ff ? S_EMUL : S_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         S_EMUL: begin
            if (head.acc > 64'sh7FFFFFFF) begin
               s_in = 32'sh7FFFFFFF;
               if (in_range) fault_in = 1'b1;
            end else if (head.acc < -64'sh80000000) begin
               s_in = 32'sh80000000;
               if (in_range) fault_in = 1'b1;
            end else begin
               s_in = head.acc[31:0];
            end
            prod_in  = s_in * head.odev;
            state_in = S_EADD;
         end
         S_EADD: begin
            scaled = prod_ff >>> FRAC_BITS;
            biased = scaled + 64'(head.omean);
            if (mode_ff != zlp_pkg::MODE_REGRESSION) begin
               val = s_ff;
            end else if (biased > 64'sh7FFFFFFF) begin
               val = 32'sh7FFFFFFF;
               if (in_range) fault_in = 1'b1;
            end else if (biased < -64'sh80000000) begin
               val = 32'sh80000000;
               if (in_range) fault_in = 1'b1;
            end else begin
               val = biased[31:0];
            end
            tail_in.acc = ACC_W'(val);
            shift_en = 1'b1;
            if (32'(cnt_ff) == MAX_OUTPUTS - 1) begin
               cnt_in   = '0;
               state_in = S_OUT;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_EMUL;
            end
         end
         S_OUT: begin
            // Results leave from the head; the ring keeps turning with cleared
            // accumulators until every cell is back home.
            tail_in.acc = '0;
            shift_en = in_range ? rsp_ready : 1'b1;
            if (shift_en) begin
               if (32'(cnt_ff) == MAX_OUTPUTS - 1) begin
                  cnt_in   = '0;
                  fault_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         fault_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fault_ff <= fault_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff  <= req_value_a;
         fa_ff <= req_fa;
      end
      z_ff    <= z_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
   end

   assign rsp_valid        = state_ff == S_OUT && in_range;
   assign rsp_result_index = 3'(cnt_ff);
   assign rsp_prediction   = head.acc[31:0];
   assign rsp_fault        = fault_ff;
   assign rsp_last_result  = 32'(cnt_ff) + 1 == 32'(out_use_ff);

endmodule
